// ===== rtl/mlds_pkg.sv =====
// Shared types and constants for the multiplexed LED display scanner.
// No dependencies; every other file of the block imports this package.
package mlds_pkg;

    // Item kinds carried on the input tuser.
    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_START = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_HALF_CYCLE   = 2'd0,
        REG_MAX_ON_US    = 2'd1,
        REG_TICKS_PER_US = 2'd2,
        REG_UNUSED       = 2'd3
    } reg_index_t;

    // Scan sequencer phases.
    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_SHIFT_LOW  = 3'd1,
        PH_SHIFT_HIGH = 3'd2,
        PH_LATCH      = 3'd3,
        PH_ON         = 3'd4
    } phase_t;

    // Pin levels toward the external shift register.
    typedef struct packed {
        logic oe_n;
        logic rck;
        logic srck;
        logic ser;
    } pins_t;

    // Configuration register set.
    typedef struct packed {
        logic [7:0] half_cycle_ticks;
        logic [7:0] max_on_us;
        logic [5:0] ticks_per_us;
    } cfg_t;

    localparam logic [15:0] TWO_US_FIXED   = 16'h0200;
    localparam logic [7:0]  MIN_WHOLE_US   = 8'd2;
    localparam logic [7:0]  HALF_CYCLE_RST = 8'd40;
    localparam logic [7:0]  MAX_ON_US_RST  = 8'd100;
    localparam logic [5:0]  TICKS_PER_US_RST = 6'd8;
    localparam pins_t       PINS_RST = '{oe_n: 1'b1, rck: 1'b0, srck: 1'b0, ser: 1'b0};

endpackage

// ===== rtl/mlds_on_time.sv =====
// On-time calculator: 8.8 brightness to on ticks per digit.
// Depends on mlds_pkg (cfg_t, constants).
module mlds_on_time
    import mlds_pkg::*;
(
    input  logic [15:0] brightness,
    input  cfg_t        cfg,
    output logic [15:0] on_ticks
);

    logic [7:0]  whole;
    logic [15:0] rem;
    logic [13:0] prod;

    always_comb
    begin
        whole = 8'd0;
        rem   = brightness;
        if (brightness >= TWO_US_FIXED)
        begin
            whole = brightness[15:8];
            // clamp above first, so a tiny max wins over the floor of two
            if (whole > cfg.max_on_us)
                whole = cfg.max_on_us;
            else if (whole < MIN_WHOLE_US)
                whole = MIN_WHOLE_US;
            rem = brightness - {whole, 8'd0};
        end
        prod     = {6'd0, whole} * {8'd0, cfg.ticks_per_us};
        on_ticks = {2'b00, prod} + {12'd0, rem[8:5]};
    end

endmodule

// ===== rtl/mlds_scan_core.sv =====
// Scan sequencer: digit store, shift/latch/on-time sequencing, result word.
// Depends on mlds_pkg and mlds_on_time.
module mlds_scan_core
    import mlds_pkg::*;
#(
    parameter int DIGITS   = 6,
    parameter int SEG_BITS = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  mode_t               mode,
    input  logic [2:0]          digit_index,
    input  logic [SEG_BITS-1:0] segments,
    input  logic [15:0]         brightness,
    input  cfg_t                cfg,
    output pins_t               res_pins,
    output logic [DIGITS-1:0]   res_digit_enable_n,
    output logic                res_busy,
    output logic                res_frame_done,
    output logic                scan_busy
);

    localparam int BC_W = $clog2(SEG_BITS + 1);

    logic [SEG_BITS-1:0] store_reg [DIGITS];
    phase_t              phase_reg, phase_next;
    logic [2:0]          digit_reg, digit_next;
    logic [BC_W-1:0]     bit_reg, bit_next;
    logic [SEG_BITS-1:0] shift_reg, shift_next;
    logic [15:0]         tick_reg, tick_next;
    logic [15:0]         on_reg, on_next;
    pins_t               pins_reg, pins_next;

    logic [15:0]         on_ticks_w;
    logic [15:0]         tick_inc;
    logic [15:0]         half;
    logic [3:0]          next_digit;
    logic [SEG_BITS-1:0] fetch;
    logic [BC_W-1:0]     bit_inc;
    pins_t               pins_out;
    phase_t              phase_out;
    logic [2:0]          digit_out;

    mlds_on_time u_on_time (
        .brightness (brightness),
        .cfg        (cfg),
        .on_ticks   (on_ticks_w)
    );

    assign tick_inc   = tick_reg + 16'd1;
    assign half       = (cfg.half_cycle_ticks == 8'd0) ? 16'd1 : {8'd0, cfg.half_cycle_ticks};
    assign next_digit = {1'b0, digit_reg} + 4'd1;
    assign bit_inc    = bit_reg + BC_W'(1);

    always_comb
    begin
        fetch = '0;
        for (int d = 0; d < DIGITS; d++)
        begin
            if (next_digit == 4'(d))
                fetch = store_reg[d];
        end
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        digit_next = digit_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        tick_next  = tick_reg;
        on_next    = on_reg;
        pins_next  = pins_reg;
        if (accept)
        begin
            case (mode)
                MODE_START:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        on_next        = on_ticks_w;
                        digit_next     = 3'd0;
                        shift_next     = store_reg[0];
                        bit_next       = '0;
                        tick_next      = 16'd0;
                        pins_next.srck = 1'b0;
                        pins_next.rck  = 1'b0;
                        pins_next.oe_n = 1'b1;
                        pins_next.ser  = store_reg[0][SEG_BITS-1];
                        phase_next     = PH_SHIFT_LOW;
                    end
                end
                MODE_TICK:
                begin
                    case (phase_reg)
                        PH_SHIFT_LOW:
                        begin
                            tick_next = tick_inc;
                            if (tick_inc >= half)
                            begin
                                tick_next      = 16'd0;
                                pins_next.srck = 1'b1;
                                phase_next     = PH_SHIFT_HIGH;
                            end
                        end
                        PH_SHIFT_HIGH:
                        begin
                            tick_next = tick_inc;
                            if (tick_inc >= half)
                            begin
                                tick_next      = 16'd0;
                                pins_next.srck = 1'b0;
                                shift_next     = {shift_reg[SEG_BITS-2:0], 1'b0};
                                bit_next       = bit_inc;
                                if (bit_inc >= BC_W'(SEG_BITS))
                                begin
                                    pins_next.rck = 1'b1;
                                    phase_next    = PH_LATCH;
                                end
                                else
                                begin
                                    pins_next.ser = shift_reg[SEG_BITS-2];
                                    phase_next    = PH_SHIFT_LOW;
                                end
                            end
                        end
                        PH_LATCH:
                        begin
                            tick_next = tick_inc;
                            if (tick_inc >= half)
                            begin
                                tick_next     = 16'd0;
                                pins_next.rck = 1'b0;
                                if (on_reg != 16'd0)
                                    pins_next.oe_n = 1'b0;
                                phase_next = PH_ON;
                            end
                        end
                        PH_ON:
                        begin
                            tick_next = tick_inc;
                            if (tick_inc >= on_reg)
                            begin
                                pins_next.oe_n = 1'b1;
                                if (next_digit >= 4'(DIGITS))
                                begin
                                    digit_next = 3'd0;
                                    tick_next  = 16'd0;
                                    phase_next = PH_IDLE;
                                end
                                else
                                begin
                                    // begin the next digit
                                    digit_next     = next_digit[2:0];
                                    shift_next     = fetch;
                                    bit_next       = '0;
                                    tick_next      = 16'd0;
                                    pins_next.srck = 1'b0;
                                    pins_next.rck  = 1'b0;
                                    pins_next.ser  = fetch[SEG_BITS-1];
                                    phase_next     = PH_SHIFT_LOW;
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    // result word: a tick shows the levels during the tick, others after the item
    always_comb
    begin
        if (mode == MODE_TICK)
        begin
            pins_out  = pins_reg;
            phase_out = phase_reg;
            digit_out = digit_reg;
        end
        else
        begin
            pins_out  = pins_next;
            phase_out = phase_next;
            digit_out = digit_next;
        end
        res_pins = pins_out;
        for (int d = 0; d < DIGITS; d++)
            res_digit_enable_n[d] = !(phase_out == PH_ON && digit_out == 3'(d));
        res_busy       = (phase_out != PH_IDLE);
        res_frame_done = (mode == MODE_TICK) && (phase_reg == PH_ON)
                         && (tick_inc >= on_reg) && (next_digit >= 4'(DIGITS));
    end

    assign scan_busy = (phase_reg != PH_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            digit_reg <= 3'd0;
            bit_reg   <= '0;
            shift_reg <= '0;
            tick_reg  <= 16'd0;
            on_reg    <= 16'd0;
            pins_reg  <= PINS_RST;
            for (int d = 0; d < DIGITS; d++)
                store_reg[d] <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            digit_reg <= digit_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            tick_reg  <= tick_next;
            on_reg    <= on_next;
            pins_reg  <= pins_next;
            // an index at or above the digit count matches no entry and is dropped
            for (int d = 0; d < DIGITS; d++)
            begin
                if (accept && mode == MODE_WRITE && digit_index == 3'(d))
                    store_reg[d] <= segments;
            end
        end
    end

endmodule

// ===== rtl/mlds_out_skid.sv =====
// Output register with a skid stage: full rate, stalling the input only while the skid stage holds a word.
// Depends on mlds_pkg only through the common import convention.
module mlds_out_skid
    import mlds_pkg::*;
#(
    parameter int W = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);

    logic         out_valid_reg;
    logic [W-1:0] out_data_reg;
    logic         skid_valid_reg;
    logic [W-1:0] skid_data_reg;
    logic         out_load;
    logic         push;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && in_ready;
    assign out_load  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= push;
                end
            end
            else if (push)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (push)
                out_data_reg <= in_data;
        end
        else if (push)
        begin
            skid_data_reg <= in_data;
        end
    end

endmodule

// ===== rtl/multiplexed_led_display_scanner.sv =====
// Multiplexed LED display scanner, top level: ports, configuration registers.
// Depends on mlds_pkg, mlds_on_time, mlds_scan_core and mlds_out_skid.
//
// The block drives a six-digit multiplexed LED display through an external
// serial-in shift register with a storage latch. Each input word is a tick,
// a digit write or a frame start (tuser); each accepted word yields exactly
// one result word holding the pin levels, the active-low digit enables and
// the busy flag, with tlast marking the tick on which the last digit ends.
// A start latches the 8.8 brightness and scans the digits in order: for each
// digit its byte is shifted out MSB first (serial data set, shift clock low
// then high, half_cycle_ticks ticks each), the latch clock pulses high for
// half_cycle_ticks, then the digit enable is pulled and output enable held low
// as one contiguous pulse of on ticks. Time advances only on tick words.
// Rate: one word per clock cycle. The whole step of the scan sequencer sits
// between the sequencer state registers and the output register, so the
// input is ready in every cycle unless both the output register and its skid
// stage hold words the sink has not taken. Configuration words are taken on
// every cycle (cfg_ready is tied high) and must arrive while the block idles.
// No clearing pass runs after reset; the digit store resets blank at once.
module multiplexed_led_display_scanner
    import mlds_pkg::*;
#(
    parameter int DIGITS   = 6,
    parameter int SEG_BITS = 8,
    localparam int S_W = ((SEG_BITS + 19 + 7) / 8) * 8,
    localparam int M_W = ((DIGITS + 5 + 7) / 8) * 8
)
(
    input  logic           clk,
    input  logic           rst_n,
    // input words
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [S_W-1:0] s_tdata,  // digit_index[2:0], segments, brightness[15:0], zero pad
    input  logic [1:0]     s_tuser,  // mode
    // result words
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [M_W-1:0] m_tdata,  // serial_data, shift_clock, latch_clock,
                                     // output_enable_n, digit_enable_n, busy_res, zero pad
    output logic           m_tlast,  // frame_done
    // configuration writes
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [1:0]     cfg_index,
    input  logic [7:0]     cfg_data
);

    cfg_t                cfg_reg;
    logic                s_accept;
    mode_t               mode;
    pins_t               res_pins;
    logic [DIGITS-1:0]   res_digit_enable_n;
    logic                res_busy;
    logic                res_frame_done;
    logic                scan_busy;
    logic [M_W:0]        res_word;
    logic [M_W:0]        out_word;
    logic                skid_ready;

    assign cfg_ready = 1'b1;
    assign s_accept  = s_tvalid && s_tready;
    assign s_tready  = skid_ready;
    assign mode      = mode_t'(s_tuser);

    // Configuration registers; writes beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_cycle_ticks <= HALF_CYCLE_RST;
            cfg_reg.max_on_us        <= MAX_ON_US_RST;
            cfg_reg.ticks_per_us     <= TICKS_PER_US_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_index_t'(cfg_index))
                REG_HALF_CYCLE:   cfg_reg.half_cycle_ticks <= cfg_data;
                REG_MAX_ON_US:    cfg_reg.max_on_us        <= cfg_data;
                REG_TICKS_PER_US: cfg_reg.ticks_per_us     <= cfg_data[5:0];
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer: advance on ticks, latch brightness on start, hold digit bytes.
    mlds_scan_core #(
        .DIGITS   (DIGITS),
        .SEG_BITS (SEG_BITS)
    ) u_core (
        .clk                (clk),
        .rst_n              (rst_n),
        .accept             (s_accept),
        .mode               (mode),
        .digit_index        (s_tdata[2:0]),
        .segments           (s_tdata[3 +: SEG_BITS]),
        .brightness         (s_tdata[3 + SEG_BITS +: 16]),
        .cfg                (cfg_reg),
        .res_pins           (res_pins),
        .res_digit_enable_n (res_digit_enable_n),
        .res_busy           (res_busy),
        .res_frame_done     (res_frame_done),
        .scan_busy          (scan_busy)
    );

    // Pack the result word; tlast rides in the top bit through the skid stage.
    assign res_word = {res_frame_done,
                       M_W'({res_busy, res_digit_enable_n, res_pins.oe_n,
                             res_pins.rck, res_pins.srck, res_pins.ser})};

    mlds_out_skid #(
        .W (M_W + 1)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_accept),
        .in_ready  (skid_ready),
        .in_data   (res_word),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_word)
    );

    assign m_tdata = out_word[M_W-1:0];
    assign m_tlast = out_word[M_W];

    // Input stalls only when a result word is waiting at the output.
    a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result word pending");

    // A lit display in an accepted result word always has exactly one digit pulled.
    a_lit_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && !res_pins.oe_n) |-> ($countones(~res_digit_enable_n) == 1))
        else $error("output enabled without a single digit selected");

    // A start always leaves a scan running.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && mode == MODE_START) |=> scan_busy)
        else $error("start word did not leave the scanner busy");

    // A frame end, which comes only from the on phase of a running scan, leaves the scanner idle.
    a_done_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && res_frame_done) |=> !scan_busy)
        else $error("frame end did not return the scanner to idle");

endmodule

// ===== tb/led_scan_checker.sv =====
// Checker for the multiplexed LED display scanner: watches the input, result and
// configuration channels, predicts each result word and compares it field by field.
// Depends on mlds_pkg for the item kinds, register indexes, phases and reset values.
module led_scan_checker
    import mlds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // digit_index[2:0], segments[7:0], brightness[15:0], pad
    input  logic [1:0]  s_tuser,   // mode
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // ser, srck, rck, oe_n, digit_enable_n[5:0], busy, pad
    input  logic        m_tlast,   // frame_done
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output int          failures
);

    localparam int DIGITS   = 6;
    localparam int SEG_BITS = 8;

    typedef struct packed {
        logic       done;
        logic       busy;
        logic [5:0] digit_en_n;
        pins_t      pins;
    } scan_word_t;

    // Shadow copy of the scanner.
    cfg_t        regs;
    logic [7:0]  seg_store [DIGITS];
    phase_t      phase;
    logic [2:0]  digit;
    logic [3:0]  bits_out;
    logic [7:0]  shreg;
    logic [15:0] ticks;
    logic [15:0] on_len;
    pins_t       pins;

    scan_word_t  predicted_words [$];
    int          mismatches;

    // On time in ticks: from two us up, whole microseconds capped at max, times ticks_per_us, plus remainder bits 8:5.
    function automatic logic [15:0] on_time_ticks(input logic [15:0] bri);
        logic [31:0] whole;
        logic [31:0] rem;
        whole = 32'd0;
        rem   = 32'(bri);
        if (bri >= TWO_US_FIXED)
        begin
            whole = 32'(bri[15:8]);
            if (whole > 32'(regs.max_on_us))
                whole = 32'(regs.max_on_us);
            else if (whole < 32'(MIN_WHOLE_US))
                whole = 32'(MIN_WHOLE_US);
            rem = (32'(bri) - (whole << 8)) & 32'hFFFF;
        end
        return 16'(whole * 32'(regs.ticks_per_us) + 32'(rem[8:5]));
    endfunction

    task automatic load_digit(input logic [2:0] d);
        shreg     = seg_store[d];
        bits_out  = 4'd0;
        ticks     = 16'd0;
        pins.srck = 1'b0;
        pins.rck  = 1'b0;
        pins.oe_n = 1'b1;
        pins.ser  = shreg[SEG_BITS-1];
        phase     = PH_SHIFT_LOW;
    endtask

    task automatic scan_advance(output logic finished);
        logic [15:0] half;
        finished = 1'b0;
        half = (regs.half_cycle_ticks == 8'd0) ? 16'd1 : 16'(regs.half_cycle_ticks);
        case (phase)
            PH_SHIFT_LOW:
            begin
                ticks++;
                if (ticks >= half)
                begin
                    ticks     = 16'd0;
                    pins.srck = 1'b1;
                    phase     = PH_SHIFT_HIGH;
                end
            end
            PH_SHIFT_HIGH:
            begin
                ticks++;
                if (ticks >= half)
                begin
                    ticks     = 16'd0;
                    pins.srck = 1'b0;
                    shreg     = shreg << 1;
                    bits_out++;
                    if (bits_out >= SEG_BITS)
                    begin
                        pins.rck = 1'b1;
                        phase    = PH_LATCH;
                    end
                    else
                    begin
                        pins.ser = shreg[SEG_BITS-1];
                        phase    = PH_SHIFT_LOW;
                    end
                end
            end
            PH_LATCH:
            begin
                ticks++;
                if (ticks >= half)
                begin
                    ticks    = 16'd0;
                    pins.rck = 1'b0;
                    // a zero on time keeps the LEDs dark for its single tick
                    if (on_len != 16'd0)
                        pins.oe_n = 1'b0;
                    phase = PH_ON;
                end
            end
            PH_ON:
            begin
                ticks++;
                if (ticks >= on_len)
                begin
                    pins.oe_n = 1'b1;
                    digit++;
                    if (digit >= DIGITS)
                    begin
                        digit    = 3'd0;
                        ticks    = 16'd0;
                        phase    = PH_IDLE;
                        finished = 1'b1;
                    end
                    else
                        load_digit(digit);
                end
            end
            default: phase = PH_IDLE;
        endcase
    endtask

    task automatic scan_step(input mode_t mode, input logic [2:0] idx, input logic [7:0] seg,
                             input logic [15:0] bri, output scan_word_t word);
        pins_t      pins_now;
        phase_t     phase_now;
        logic [2:0] digit_now;
        logic       finished;
        finished = 1'b0;
        if (mode == MODE_WRITE)
        begin
            if (idx < DIGITS)
                seg_store[idx] = seg;
        end
        else if (mode == MODE_START && phase == PH_IDLE)
        begin
            on_len = on_time_ticks(bri);
            digit  = 3'd0;
            load_digit(3'd0);
        end
        pins_now  = pins;
        phase_now = phase;
        digit_now = digit;
        if (mode == MODE_TICK)
            scan_advance(finished);
        word.pins       = pins_now;
        word.digit_en_n = (phase_now == PH_ON) ? ~(6'd1 << digit_now) : 6'h3F;
        word.busy       = (phase_now != PH_IDLE);
        word.done       = finished;
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t checker: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        scan_word_t want;
        if (!rst_n)
        begin
            regs = '{half_cycle_ticks: HALF_CYCLE_RST, max_on_us: MAX_ON_US_RST,
                     ticks_per_us: TICKS_PER_US_RST};
            foreach (seg_store[i])
                seg_store[i] = 8'd0;
            phase    = PH_IDLE;
            digit    = 3'd0;
            bits_out = 4'd0;
            shreg    = 8'd0;
            ticks    = 16'd0;
            on_len   = 16'd0;
            pins     = PINS_RST;
            predicted_words.delete();
            mismatches = 0;
        end
        else
        begin
            // compare before predicting: a word accepted now cannot be answered now
            if (m_tvalid && m_tready)
            begin
                if (predicted_words.size() == 0)
                begin
                    mismatches++;
                    $display("%0t checker: result word %h tlast %b with nothing expected",
                             $time, m_tdata, m_tlast);
                end
                else
                begin
                    want = predicted_words.pop_front();
                    check_field("serial_data", 8'(want.pins.ser), 8'(m_tdata[0]));
                    check_field("shift_clock", 8'(want.pins.srck), 8'(m_tdata[1]));
                    check_field("latch_clock", 8'(want.pins.rck), 8'(m_tdata[2]));
                    check_field("output_enable_n", 8'(want.pins.oe_n), 8'(m_tdata[3]));
                    check_field("digit_enable_n", 8'(want.digit_en_n), 8'(m_tdata[9:4]));
                    check_field("busy", 8'(want.busy), 8'(m_tdata[10]));
                    check_field("frame_done", 8'(want.done), 8'(m_tlast));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (reg_index_t'(cfg_index))
                    REG_HALF_CYCLE:   regs.half_cycle_ticks = cfg_data;
                    REG_MAX_ON_US:    regs.max_on_us        = cfg_data;
                    REG_TICKS_PER_US: regs.ticks_per_us     = cfg_data[5:0];
                    default:          ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                scan_step(mode_t'(s_tuser), s_tdata[2:0], s_tdata[10:3], s_tdata[26:11], want);
                predicted_words.push_back(want);
            end
        end
        failures = mismatches + predicted_words.size();
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the scanner testbench: clock, reset, stimulus on the input and configuration
// channels, random backpressure on the result channel, watchdog and verdict.
// Depends on mlds_pkg, multiplexed_led_display_scanner and led_scan_checker.
module testbench;
    import mlds_pkg::*;

    localparam int IN_W            = 32;    // input word width at the default parameters
    localparam int RES_W           = 16;    // result word width at the default parameters
    localparam int BUSY_BIT        = 10;
    localparam int WATCHDOG_LIMIT  = 4000;  // cycles with no handshake on any channel
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int RANDOM_WORDS    = 30;
    localparam int DRAIN_BURST     = 16;
    localparam int SETTLE_CYCLES   = 8;
    localparam int SETTINGS_STEPS  = 4;
    localparam int RESET_TICKS     = 50;    // ticks of the frame run at reset timing
    localparam int OPENING_TICKS   = 60;    // ticks of the frame run at the top corners

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata   = '0;   // digit_index[2:0], segments[7:0], brightness[15:0], pad
    logic [1:0]       s_tuser   = '0;   // mode
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [RES_W-1:0] m_tdata;          // ser, srck, rck, oe_n, digit_enable_n[5:0], busy, pad
    logic             m_tlast;          // frame_done
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [1:0]       cfg_index = '0;
    logic [7:0]       cfg_data  = '0;
    int               failures;

    int   gap_pct      = 0;    // chance in percent that the sender idles a cycle
    int   stall_pct    = 0;    // chance in percent that the receiver stalls a cycle
    bit   hold_req     = 1'b0; // ask the receiver for one long hold-off
    int   hold_left    = 0;
    int   words_sent   = 0;
    int   words_back   = 0;
    logic last_busy    = 1'b0; // busy flag of the newest result word
    int   quiet_cycles = 0;

    multiplexed_led_display_scanner dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    led_scan_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .failures  (failures)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Result side: stall at random, or hold off for a long stretch when asked so the
    // output register and skid stage fill and the block drops s_tready.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready = 1'b0;
            hold_left--;
        end
        else if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_OFF_CYCLES - 1;
            m_tready  = 1'b0;
        end
        else
            m_tready = ($urandom_range(0, 99) >= stall_pct);
    end

    // Count returned words and remember the busy flag, so the stimulus knows when the
    // scan has gone idle.
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            words_back <= words_back + 1;
            last_busy  <= m_tdata[BUSY_BIT];
        end
    end

    // Watchdog: end the run if no channel moves a word for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Offer one input word at the falling edge, after any random idle cycles, and hold
    // it until the block takes it. Returns right after the accepting rising edge.
    task automatic send_word(input mode_t mode, input logic [2:0] idx, input logic [7:0] seg,
                             input logic [15:0] bri);
        @(negedge clk);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = mode;
        s_tdata  = {5'd0, bri, seg, idx};
        do
            @(posedge clk);
        while (!s_tready);
        words_sent++;
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [7:0] value);
        @(negedge clk);
        s_tvalid  = 1'b0;
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Drop the input before the next rising edge so the last word is not offered
    // again, then wait for every result word.
    task automatic wait_results();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (words_back != words_sent)
            @(negedge clk);
    endtask

    // Keep ticking in bursts until a result shows the scan idle, then let the pipe settle.
    task automatic scan_to_idle();
        for (int burst = 0; burst < 2000; burst++)
        begin
            repeat (DRAIN_BURST)
                send_word(MODE_TICK, 3'($urandom), 8'($urandom), 16'($urandom));
            wait_results();
            if (!last_busy)
                break;
        end
        @(negedge clk);
        s_tvalid = 1'b0;
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // Mostly short on times, so frames finish often; now and then the full range.
    function automatic logic [15:0] pick_brightness();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 16'($urandom_range(0, 16'h01FF));
        else if (roll < 90)
            return {8'($urandom_range(2, 5)), 8'($urandom)};
        else
            return 16'($urandom);
    endfunction

    task automatic send_random_word();
        int    roll;
        mode_t mode;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            mode = MODE_TICK;
        else if (roll < 82)
            mode = MODE_WRITE;
        else if (roll < 92)
            mode = MODE_START;
        else
            mode = MODE_NOP;
        send_word(mode, 3'($urandom_range(0, 7)), 8'($urandom), pick_brightness());
    endtask

    // Register settings for the random phases: short shift timing so frames complete,
    // with the zero and minimum corners of every register among them.
    task automatic apply_setting(input int step);
        logic [7:0] half;
        logic [7:0] max_on;
        logic [7:0] per_us;
        case (step)
            0:       begin half = 8'd1; max_on = 8'd2;   per_us = 8'd1;  end
            1:       begin half = 8'd0; max_on = 8'd0;   per_us = 8'd0;  end
            2:       begin half = 8'd2; max_on = 8'd1;   per_us = 8'd63; end
            default: begin half = 8'd1; max_on = 8'd6;   per_us = 8'd32; end
        endcase
        write_reg(REG_HALF_CYCLE, half);
        write_reg(REG_MAX_ON_US, max_on);
        write_reg(REG_TICKS_PER_US, per_us);
    endtask

    initial
    begin
        logic [15:0] edge_bri [4];
        logic [7:0]  patterns [6];
        edge_bri = '{16'h01FF, 16'h0200, 16'hFFFF, 16'h0000};
        patterns = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hA5, 8'h5A};

        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset register values: load every digit, try writes
        // past the last digit, a no-op, ticks while idle, then a frame with zero
        // on time, a start while busy and a write during the scan. The opening of
        // the frame runs at reset timing, the rest at the shortest shift clock.
        for (int d = 0; d < 6; d++)
            send_word(MODE_WRITE, 3'(d), patterns[d], 16'($urandom));
        send_word(MODE_WRITE, 3'd6, 8'hFF, 16'h0000);
        send_word(MODE_WRITE, 3'd7, 8'h00, 16'hFFFF);
        send_word(MODE_NOP, 3'd7, 8'hFF, 16'hFFFF);
        send_word(MODE_TICK, 3'd0, 8'h00, 16'h0000);
        send_word(MODE_TICK, 3'd7, 8'hFF, 16'hFFFF);
        send_word(MODE_START, 3'd0, 8'h00, 16'h0000);
        send_word(MODE_START, 3'd0, 8'h00, 16'hFFFF);
        send_word(MODE_WRITE, 3'd5, 8'h3C, 16'h0000);
        send_word(MODE_NOP, 3'd0, 8'h00, 16'h0000);
        repeat (RESET_TICKS)
            send_word(MODE_TICK, 3'($urandom), 8'($urandom), 16'($urandom));
        wait_results();
        write_reg(REG_HALF_CYCLE, 8'd1);
        scan_to_idle();

        for (int step = 0; step < SETTINGS_STEPS; step++)
        begin
            apply_setting(step);
            // rotate the idling pattern: none, sender, receiver, both
            case (step % 4)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 72; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 72; end
                default: begin gap_pct = 29; stall_pct = 29; end
            endcase
            // brightness corners: fraction only, exactly two us, clamp, zero
            if (step == 0)
            begin
                foreach (edge_bri[i])
                begin
                    send_word(MODE_START, 3'($urandom), 8'($urandom), edge_bri[i]);
                    scan_to_idle();
                end
            end
            for (int n = 0; n < RANDOM_WORDS; n++)
            begin
                // one long receiver hold-off while the sender keeps offering words
                if (step == 0 && n == 10)
                    hold_req = 1'b1;
                send_random_word();
            end
            scan_to_idle();
        end

        // Top corners of every register, and a write to the spare index. The frame
        // is far too long to finish, so only its opening is checked.
        gap_pct   = 0;
        stall_pct = 0;
        write_reg(REG_HALF_CYCLE, 8'd255);
        write_reg(REG_MAX_ON_US, 8'd255);
        write_reg(REG_TICKS_PER_US, 8'hFF);
        write_reg(REG_UNUSED, 8'hFF);
        send_word(MODE_START, 3'd0, 8'h00, 16'hFFFF);
        repeat (OPENING_TICKS)
            send_word(MODE_TICK, 3'($urandom), 8'($urandom), 16'($urandom));
        @(negedge clk);
        s_tvalid = 1'b0;
        wait_results();
        repeat (SETTLE_CYCLES)
            @(negedge clk);

        if (failures == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
